>>> rtl/core/rgl_pkg.sv
// Package for the replay guard ledger: table sizing, field widths,
// result status codes and sequencer state type. No dependencies.
package rgl_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int CHAL_W      = 128;
    localparam int HALF_W      = 64;
    localparam int GEN_W       = 64;
    localparam int STATUS_W    = 2;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int IN_W        = 2 * HALF_W;
    localparam int OUT_RAW_W   = STATUS_W + GEN_W;
    localparam int OUT_W       = ((OUT_RAW_W + 7) / 8) * 8;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
    localparam logic [GEN_W-1:0] GEN_MAX   = {GEN_W{1'b1}};

    typedef enum logic [STATUS_W-1:0] {
        ST_REGISTERED = 2'd0,
        ST_INVALID    = 2'd1,
        ST_REPLAY     = 2'd2,
        ST_FULL       = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_POST
    } state_t;

endpackage

>>> rtl/core/rgl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; contents are undefined until written.
module rgl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/replay_guard_ledger.sv
// Replay guard ledger: challenge table scan with generation assignment.
// Depends on rgl_pkg and rgl_ram.
// One request at a time: s_tready is high only in idle, and the next request is taken
// after the result has been posted. The scan compares one table entry per cycle; a zero
// challenge skips the scan, and a replay ends it at the matching entry.
// Reset: async, active low; clears count and state.
module replay_guard_ledger (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [rgl_pkg::IN_W-1:0]   s_tdata,  // challenge_high, challenge_low
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [rgl_pkg::OUT_W-1:0]  m_tdata   // status, assigned_generation, zero pad
);

    import rgl_pkg::*;

    state_t              state_reg,     state_next;
    logic [CHAL_W-1:0]   chal_reg,      chal_next;
    logic [CNT_W-1:0]    idx_reg,       idx_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic [CNT_W-1:0]    count_reg,     count_next;
    logic [GEN_W-1:0]    gen_reg,       gen_next;
    status_t             pend_st_reg,   pend_st_next;
    logic [GEN_W-1:0]    pend_gen_reg,  pend_gen_next;
    logic                m_valid_reg,   m_valid_next;
    status_t             out_st_reg,    out_st_next;
    logic [GEN_W-1:0]    out_gen_reg,   out_gen_next;

    logic                ram_we;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [CHAL_W-1:0]   ram_rdata;
    logic                out_free;

    rgl_ram #(
        .WIDTH (CHAL_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (chal_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free = !m_valid_reg || m_tready;

    always_comb
    begin
        state_next     = state_reg;
        chal_next      = chal_reg;
        idx_next       = idx_reg;
        cmp_valid_next = 1'b0;
        count_next     = count_reg;
        gen_next       = gen_reg;
        pend_st_next   = pend_st_reg;
        pend_gen_next  = pend_gen_reg;
        m_valid_next   = m_valid_reg;
        out_st_next    = out_st_reg;
        out_gen_next   = out_gen_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = idx_reg[ADDR_W-1:0];
        s_tready       = 1'b0;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    chal_next  = s_tdata;
                    idx_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (chal_reg == '0)
                begin
                    pend_st_next  = ST_INVALID;
                    pend_gen_next = '0;
                    state_next    = S_POST;
                end
                else if (cmp_valid_reg && (ram_rdata == chal_reg))
                begin
                    pend_st_next  = ST_REPLAY;
                    pend_gen_next = '0;
                    state_next    = S_POST;
                end
                else if (idx_reg < count_reg)
                begin
                    ram_re         = 1'b1;
                    idx_next       = idx_reg + 1'b1;
                    cmp_valid_next = 1'b1;
                end
                else if ((count_reg == DEPTH_CNT) || (gen_reg == GEN_MAX))
                begin
                    pend_st_next  = ST_FULL;
                    pend_gen_next = '0;
                    state_next    = S_POST;
                end
                else
                begin
                    ram_we        = 1'b1;
                    count_next    = count_reg + 1'b1;
                    gen_next      = gen_reg + 1'b1;
                    pend_st_next  = ST_REGISTERED;
                    pend_gen_next = gen_reg + 1'b1;
                    state_next    = S_POST;
                end
            end
            S_POST:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    out_st_next  = pend_st_reg;
                    out_gen_next = pend_gen_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            count_reg     <= '0;
            gen_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cmp_valid_reg <= cmp_valid_next;
            count_reg     <= count_next;
            gen_reg       <= gen_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chal_reg     <= chal_next;
        pend_st_reg  <= pend_st_next;
        pend_gen_reg <= pend_gen_next;
        out_st_reg   <= out_st_next;
        out_gen_reg  <= out_gen_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_W - OUT_RAW_W){1'b0}}, out_gen_reg, out_st_reg};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("entry count beyond table depth");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= count_reg)
        else $error("scan index beyond entry count");

    a_count_gen_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (gen_reg == $past(gen_reg) + 1'b1))
        else $error("entry count moved without generation step");

    a_gen_registered: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && (out_st_reg == ST_REGISTERED)) |-> (out_gen_reg != '0))
        else $error("registered result with zero generation");

    a_gen_zero_else: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && (out_st_reg != ST_REGISTERED)) |-> (out_gen_reg == '0))
        else $error("rejected result with nonzero generation");
`endif

endmodule

>>> sim/replay_guard_ledger_test.sv
// Self-checking bench for replay_guard_ledger: streams 128-bit challenges
// through the request port and checks every status and generation result.
// Depends on rgl_pkg and the replay_guard_ledger RTL.
`timescale 1ns / 1ps

module replay_guard_ledger_test;

    import rgl_pkg::*;

    localparam int RANDOM_ITEMS = 400;
    localparam int PHASE_LEN    = 140;
    localparam int SETTLE_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        logic [HALF_W-1:0] hi;
        logic [HALF_W-1:0] lo;
        bit                drain;
    } challenge_t;

    typedef struct {
        status_t          status;
        logic [GEN_W-1:0] generation;
    } verdict_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_W-1:0]    m_tdata;

    challenge_t          challenge_q[$];
    logic [CHAL_W-1:0]   issued[$];
    verdict_t            expected_verdicts[$];

    logic [CHAL_W-1:0]   ledger_seen[TABLE_DEPTH];
    int                  ledger_count = 0;
    logic [GEN_W-1:0]    ledger_gen = '0;

    bit                  req_taken = 1'b0;
    int                  req_count = 0;
    int                  result_count = 0;
    int                  mismatches = 0;
    int                  status_hits[4] = '{0, 0, 0, 0};
    longint              cycles = 0;

    replay_guard_ledger dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    function automatic verdict_t ledger_predict(logic [HALF_W-1:0] hi, logic [HALF_W-1:0] lo);
        verdict_t          v;
        logic [CHAL_W-1:0] key;
        bit                hit;
        key = {hi, lo};
        v.status = ST_REGISTERED;
        v.generation = '0;
        hit = 1'b0;
        if (key == '0) begin
            v.status = ST_INVALID;
        end
        else begin
            for (int i = 0; i < ledger_count; i++) begin
                if (ledger_seen[i] == key)
                    hit = 1'b1;
            end
            if (hit) begin
                v.status = ST_REPLAY;
            end
            else if (ledger_count >= TABLE_DEPTH || ledger_gen == GEN_MAX) begin
                v.status = ST_FULL;
            end
            else begin
                ledger_seen[ledger_count] = key;
                ledger_count++;
                ledger_gen++;
                v.generation = ledger_gen;
            end
        end
        return v;
    endfunction

    task automatic queue_challenge(logic [HALF_W-1:0] hi, logic [HALF_W-1:0] lo, bit drain);
        challenge_t c;
        c.hi = hi;
        c.lo = lo;
        c.drain = drain;
        challenge_q.push_back(c);
        if ({hi, lo} != '0)
            issued.push_back({hi, lo});
    endtask

    task automatic note_mismatch(string what, verdict_t want, status_t got_st,
                                 logic [GEN_W-1:0] got_gen);
        if (mismatches < 10)
            $display("mismatch at result %0d (%s): expected %s gen %0d, got %s gen %0d",
                     result_count, what, want.status.name(), want.generation,
                     got_st.name(), got_gen);
        mismatches++;
    endtask

    // drive requests and result backpressure on the falling edge
    always @(negedge clk) begin : drive
        challenge_t c;
        bit         nv;
        int         send_idle;
        int         recv_idle;
        if (req_count < PHASE_LEN) begin
            send_idle = 21;
            recv_idle = 69;
        end
        else if (req_count < 2 * PHASE_LEN) begin
            send_idle = 69;
            recv_idle = 21;
        end
        else begin
            send_idle = 0;
            recv_idle = 0;
        end
        if (rst_n) begin
            m_tready <= ($urandom_range(99) >= recv_idle);
            if (!(s_tvalid && !req_taken)) begin
                nv = 1'b0;
                if (challenge_q.size() > 0) begin
                    c = challenge_q[0];
                    if (!(c.drain && expected_verdicts.size() != 0)
                        && $urandom_range(99) >= send_idle) begin
                        void'(challenge_q.pop_front());
                        s_tdata <= {c.lo, c.hi};
                        nv = 1'b1;
                    end
                end
                s_tvalid <= nv;
            end
        end
    end

    // predict on accepted requests, check accepted results
    always @(posedge clk or negedge rst_n) begin : watch
        verdict_t          want;
        status_t           got_st;
        logic [GEN_W-1:0]  got_gen;
        if (!rst_n) begin
            req_taken <= 1'b0;
        end
        else begin
            req_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                expected_verdicts.push_back(
                    ledger_predict(s_tdata[HALF_W-1:0], s_tdata[IN_W-1:HALF_W]));
                req_count++;
            end
            if (m_tvalid && m_tready) begin
                got_st = status_t'(m_tdata[STATUS_W-1:0]);
                got_gen = m_tdata[STATUS_W+GEN_W-1:STATUS_W];
                status_hits[int'(got_st)]++;
                if (expected_verdicts.size() == 0) begin
                    want.status = ST_INVALID;
                    want.generation = '0;
                    note_mismatch("nothing pending", want, got_st, got_gen);
                end
                else begin
                    want = expected_verdicts.pop_front();
                    if (got_st !== want.status)
                        note_mismatch("status", want, got_st, got_gen);
                    else if (got_gen !== want.generation)
                        note_mismatch("generation", want, got_st, got_gen);
                end
                result_count++;
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycles, expected_verdicts.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        logic [HALF_W-1:0] hi;
        logic [HALF_W-1:0] lo;
        logic [CHAL_W-1:0] pick;
        int                roll;
        // directed: zero, extremes, replays, near misses
        queue_challenge('0, '0, 1'b0);
        queue_challenge('1, '0, 1'b0);
        queue_challenge('0, '1, 1'b0);
        queue_challenge('0, 64'd1, 1'b0);
        queue_challenge(64'h8000_0000_0000_0000, '0, 1'b0);
        queue_challenge('1, '1, 1'b0);
        queue_challenge('1, '1, 1'b0);
        queue_challenge('1, '0, 1'b0);
        queue_challenge('1, 64'd1, 1'b0);
        queue_challenge('0, 64'd1, 1'b0);
        queue_challenge('0, '0, 1'b0);
        queue_challenge(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        queue_challenge(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0);
        queue_challenge(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            roll = $urandom_range(99);
            hi = {$urandom, $urandom};
            lo = {$urandom, $urandom};
            if (roll < 10) begin
                hi = '0;
                lo = '0;
            end
            else if (roll < 40) begin
                pick = issued[$urandom_range(issued.size() - 1)];
                {hi, lo} = pick;
            end
            else if (roll < 55) begin
                pick = issued[$urandom_range(issued.size() - 1)];
                pick[$urandom_range(CHAL_W - 1)] ^= 1'b1;
                {hi, lo} = pick;
            end
            else if (roll < 62) begin
                if ($urandom_range(1))
                    hi = '0;
                else
                    lo = '0;
            end
            queue_challenge(hi, lo, (n == 0 || n == RANDOM_ITEMS / 2));
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (challenge_q.size() != 0 || s_tvalid || expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (expected_verdicts.size() != 0) begin
            $display("%0d results never arrived", expected_verdicts.size());
            mismatches += expected_verdicts.size();
        end
        $display("%0d requests, %0d results in %0d cycles; table holds %0d, generation %0d",
                 req_count, result_count, cycles, ledger_count, ledger_gen);
        $display("registered %0d, invalid %0d, replay %0d, full %0d, mismatches %0d",
                 status_hits[ST_REGISTERED], status_hits[ST_INVALID],
                 status_hits[ST_REPLAY], status_hits[ST_FULL], mismatches);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
